/* rtl/s256_pkg.sv */
// Shared types, constants and round functions for the SHA-256 stream hasher.
// No dependencies; the core and the top level refer to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package s256_pkg;

   // Eight 32-bit chaining or working words, word 0 (a / H0) at index 0
   typedef logic [7:0][31:0] chain_type;

   // Initial hash value, written highest index first
   localparam chain_type INIT_H = {
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
   };

   localparam logic [7:0] PAD_MARK   = 8'h80;
   localparam logic [5:0] LEN_POS    = 6'd56;
   localparam logic [5:0] LAST_SLOT  = 6'd63;
   localparam logic [5:0] LAST_ROUND = 6'd63;
   localparam logic [2:0] LAST_INDEX = 3'd7;

   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   // Sequencer states of the top level
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_PAD  = 5'b00010,
      ST_LEN  = 5'b00100,
      ST_COMP = 5'b01000,
      ST_OUT  = 5'b10000
   } seq_state_type;

   // States of the compression core
   typedef enum logic [2:0] {
      CORE_IDLE  = 3'b001,
      CORE_ROUND = 3'b010,
      CORE_ADD   = 3'b100
   } core_state_type;

   // Sequencer to core
   typedef struct packed {
      logic       shift_byte;  // push one byte into the message line
      logic [7:0] byte_val;
      logic       start;       // load working words and run one block
      logic       reinit;      // restore the initial hash value
   } core_ctrl_type;

   // Core to sequencer
   typedef struct packed {
      logic busy;
      logic done;              // final add happens on this cycle
   } core_stat_type;

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
   endfunction

   // Round constants
   function automatic logic [31:0] round_k(input logic [5:0] idx);
      case (idx)
         6'd0:  round_k = 32'h428a2f98;
         6'd1:  round_k = 32'h71374491;
         6'd2:  round_k = 32'hb5c0fbcf;
         6'd3:  round_k = 32'he9b5dba5;
         6'd4:  round_k = 32'h3956c25b;
         6'd5:  round_k = 32'h59f111f1;
         6'd6:  round_k = 32'h923f82a4;
         6'd7:  round_k = 32'hab1c5ed5;
         6'd8:  round_k = 32'hd807aa98;
         6'd9:  round_k = 32'h12835b01;
         6'd10: round_k = 32'h243185be;
         6'd11: round_k = 32'h550c7dc3;
         6'd12: round_k = 32'h72be5d74;
         6'd13: round_k = 32'h80deb1fe;
         6'd14: round_k = 32'h9bdc06a7;
         6'd15: round_k = 32'hc19bf174;
         6'd16: round_k = 32'he49b69c1;
         6'd17: round_k = 32'hefbe4786;
         6'd18: round_k = 32'h0fc19dc6;
         6'd19: round_k = 32'h240ca1cc;
         6'd20: round_k = 32'h2de92c6f;
         6'd21: round_k = 32'h4a7484aa;
         6'd22: round_k = 32'h5cb0a9dc;
         6'd23: round_k = 32'h76f988da;
         6'd24: round_k = 32'h983e5152;
         6'd25: round_k = 32'ha831c66d;
         6'd26: round_k = 32'hb00327c8;
         6'd27: round_k = 32'hbf597fc7;
         6'd28: round_k = 32'hc6e00bf3;
         6'd29: round_k = 32'hd5a79147;
         6'd30: round_k = 32'h06ca6351;
         6'd31: round_k = 32'h14292967;
         6'd32: round_k = 32'h27b70a85;
         6'd33: round_k = 32'h2e1b2138;
         6'd34: round_k = 32'h4d2c6dfc;
         6'd35: round_k = 32'h53380d13;
         6'd36: round_k = 32'h650a7354;
         6'd37: round_k = 32'h766a0abb;
         6'd38: round_k = 32'h81c2c92e;
         6'd39: round_k = 32'h92722c85;
         6'd40: round_k = 32'ha2bfe8a1;
         6'd41: round_k = 32'ha81a664b;
         6'd42: round_k = 32'hc24b8b70;
         6'd43: round_k = 32'hc76c51a3;
         6'd44: round_k = 32'hd192e819;
         6'd45: round_k = 32'hd6990624;
         6'd46: round_k = 32'hf40e3585;
         6'd47: round_k = 32'h106aa070;
         6'd48: round_k = 32'h19a4c116;
         6'd49: round_k = 32'h1e376c08;
         6'd50: round_k = 32'h2748774c;
         6'd51: round_k = 32'h34b0bcb5;
         6'd52: round_k = 32'h391c0cb3;
         6'd53: round_k = 32'h4ed8aa4a;
         6'd54: round_k = 32'h5b9cca4f;
         6'd55: round_k = 32'h682e6ff3;
         6'd56: round_k = 32'h748f82ee;
         6'd57: round_k = 32'h78a5636f;
         6'd58: round_k = 32'h84c87814;
         6'd59: round_k = 32'h8cc70208;
         6'd60: round_k = 32'h90befffa;
         6'd61: round_k = 32'ha4506ceb;
         6'd62: round_k = 32'hbef9a3f7;
         6'd63: round_k = 32'hc67178f2;
         default: round_k = 32'h00000000;
      endcase
   endfunction

endpackage

`default_nettype wire

/* rtl/s256_req_if.sv */
// Input channel of the SHA-256 stream hasher: one message byte or a finish per word.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface s256_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

`default_nettype wire

/* rtl/s256_rsp_if.sv */
// Result channel of the SHA-256 stream hasher: one digest word per handshake.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface s256_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);
endinterface

`default_nettype wire

/* rtl/sha256_stream_hasher.sv */
// Top level of the SHA-256 stream hasher: byte intake, padding sequencer, digest output.
// Depends on s256_pkg, s256_req_if, s256_rsp_if and s256_core.
`timescale 1ns / 1ps
`default_nettype none

// Streaming SHA-256. Each req word carries one message byte (kind 0) or a finish
// (kind 1). Every 64th data byte holds req_bus.ready low while the single round
// unit runs 64 rounds and the final add. A finish feeds the padding one byte per
// cycle while no compression runs (0x80, zeros up to byte 56, eight length bytes),
// with one or two compressions in between, and then presents the eight digest words
// on rsp_bus, word 0 first, last_word set on word 7. After the final word the
// hasher is back in its reset state, ready for the next message.
module sha256_stream_hasher (
   input wire         clock,
   input wire         reset,
   s256_req_if.sink   req_bus,
   s256_rsp_if.source rsp_bus
);

   s256_pkg::seq_state_type state_ff, state_in;
   s256_pkg::seq_state_type ret_ff, ret_in;
   logic [5:0]              fill_ff, fill_in;
   logic [60:0]             count_ff, count_in;
   logic [63:0]             len_ff, len_in;
   logic                    mark_ff, mark_in;
   logic [2:0]              idx_ff, idx_in;

   s256_pkg::core_ctrl_type core_ctrl;
   s256_pkg::core_stat_type core_stat;
   s256_pkg::chain_type     chain;

   logic req_fire, rsp_fire;

   s256_core u_core (
      .clock (clock),
      .reset (reset),
      .ctrl  (core_ctrl),
      .stat  (core_stat),
      .chain (chain)
   );

   assign req_bus.ready = (state_ff == s256_pkg::ST_IDLE);
   assign rsp_bus.valid = (state_ff == s256_pkg::ST_OUT);
   assign req_fire      = req_bus.valid && req_bus.ready;
   assign rsp_fire      = rsp_bus.valid && rsp_bus.ready;

   // Sequencer: intake, padding, length, compression wait, digest output
   always_comb begin
      state_in  = state_ff;
      ret_in    = ret_ff;
      count_in  = count_ff;
      len_in    = len_ff;
      mark_in   = mark_ff;
      idx_in    = idx_ff;
      core_ctrl = '0;
      case (state_ff)
         s256_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_bus.kind == s256_pkg::KIND_DATA) begin
                  core_ctrl.shift_byte = 1'b1;
                  core_ctrl.byte_val   = req_bus.data_byte;
                  count_in             = count_ff + 61'd1;
               end else begin
                  len_in   = {count_ff, 3'b000};
                  count_in = 61'd0;
                  mark_in  = 1'b1;
                  state_in = s256_pkg::ST_PAD;
               end
            end
         end
         s256_pkg::ST_PAD: begin
            if (mark_ff || fill_ff != s256_pkg::LEN_POS) begin
               core_ctrl.shift_byte = 1'b1;
               core_ctrl.byte_val   = mark_ff ? s256_pkg::PAD_MARK : 8'h00;
               mark_in              = 1'b0;
            end else begin
               state_in = s256_pkg::ST_LEN;
            end
         end
         s256_pkg::ST_LEN: begin
            core_ctrl.shift_byte = 1'b1;
            core_ctrl.byte_val   = len_ff[63:56];
            len_in               = {len_ff[55:0], 8'h00};
         end
         s256_pkg::ST_COMP: begin
            if (core_stat.done) begin
               state_in = ret_ff;
               idx_in   = 3'd0;
            end
         end
         s256_pkg::ST_OUT: begin
            if (rsp_fire) begin
               idx_in = idx_ff + 3'd1;
               if (idx_ff == s256_pkg::LAST_INDEX) begin
                  core_ctrl.reinit = 1'b1;
                  state_in         = s256_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = s256_pkg::ST_IDLE;
         end
      endcase

      // A byte that completes the block starts a compression
      fill_in = fill_ff;
      if (core_ctrl.shift_byte) begin
         fill_in = fill_ff + 6'd1;
         if (fill_ff == s256_pkg::LAST_SLOT) begin
            core_ctrl.start = 1'b1;
            ret_in          = (state_ff == s256_pkg::ST_LEN) ? s256_pkg::ST_OUT : state_ff;
            state_in        = s256_pkg::ST_COMP;
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= s256_pkg::ST_IDLE;
         ret_ff   <= s256_pkg::ST_IDLE;
         fill_ff  <= 6'd0;
         count_ff <= 61'd0;
         mark_ff  <= 1'b0;
         idx_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
         mark_ff  <= mark_in;
         idx_ff   <= idx_in;
      end
   end

   // Bit length being shifted out
   always_ff @(posedge clock) begin
      len_ff <= len_in;
   end

   // Digest word output straight from the chaining registers
   assign rsp_bus.digest_word = chain[idx_ff];
   assign rsp_bus.word_index  = idx_ff;
   assign rsp_bus.last_word   = (idx_ff == s256_pkg::LAST_INDEX);

`ifndef SYNTHESIS
   // The digest goes out only after the final block has emptied the byte buffer
   a_out_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == s256_pkg::ST_OUT) |-> (fill_ff == 6'd0))
      else $error("hasher: digest output with bytes still buffered");

   // Intake is never open while the core is compressing
   a_ready_core: assert property (@(posedge clock) disable iff (reset)
      req_bus.ready |-> !core_stat.busy)
      else $error("hasher: ready while core busy");

   // The 64th data byte starts a compression
   a_full_block: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_bus.kind == s256_pkg::KIND_DATA
       && fill_ff == s256_pkg::LAST_SLOT)
      |=> (core_stat.busy && state_ff == s256_pkg::ST_COMP))
      else $error("hasher: full block did not start compression");

   // After the last digest word the hasher is back in its reset state
   a_reinit: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_bus.last_word)
      |=> (state_ff == s256_pkg::ST_IDLE && count_ff == 61'd0 && fill_ff == 6'd0))
      else $error("hasher: not reinitialized after digest");
`endif

endmodule

`default_nettype wire

/* rtl/s256_core.sv */
// SHA-256 compression core: 512-bit message line, one round unit, chaining words.
// Depends on s256_pkg.
`timescale 1ns / 1ps
`default_nettype none

module s256_core (
   input  wire                     clock,
   input  wire                     reset,
   input  s256_pkg::core_ctrl_type ctrl,
   output s256_pkg::core_stat_type stat,
   output s256_pkg::chain_type     chain
);

   s256_pkg::core_state_type state_ff, state_in;
   logic [5:0]               rnd_ff, rnd_in;
   s256_pkg::chain_type      chain_ff, chain_in;
   s256_pkg::chain_type      wk_ff, wk_in;
   logic [511:0]             msg_ff, msg_in;

   logic [31:0] w0, w1, w9, w14, w_new;
   logic [31:0] t1, t2, ch, maj;

   // Schedule taps: the oldest word sits at the top of the line
   assign w0  = msg_ff[511:480];
   assign w1  = msg_ff[479:448];
   assign w9  = msg_ff[223:192];
   assign w14 = msg_ff[63:32];
   assign w_new = w0 + s256_pkg::small_sigma0(w1) + w9 + s256_pkg::small_sigma1(w14);

   // Round function
   assign ch  = (wk_ff[4] & wk_ff[5]) ^ (~wk_ff[4] & wk_ff[6]);
   assign maj = (wk_ff[0] & wk_ff[1]) ^ (wk_ff[0] & wk_ff[2]) ^ (wk_ff[1] & wk_ff[2]);
   assign t1  = wk_ff[7] + s256_pkg::big_sigma1(wk_ff[4]) + ch
                + s256_pkg::round_k(rnd_ff) + w0;
   assign t2  = s256_pkg::big_sigma0(wk_ff[0]) + maj;

   // Sequencing of one block
   always_comb begin
      state_in = state_ff;
      rnd_in   = rnd_ff;
      chain_in = chain_ff;
      wk_in    = wk_ff;
      msg_in   = msg_ff;
      case (state_ff)
         s256_pkg::CORE_IDLE: begin
            if (ctrl.shift_byte) begin
               msg_in = {msg_ff[503:0], ctrl.byte_val};
            end
            if (ctrl.start) begin
               wk_in    = chain_ff;
               rnd_in   = 6'd0;
               state_in = s256_pkg::CORE_ROUND;
            end
            if (ctrl.reinit) begin
               chain_in = s256_pkg::INIT_H;
            end
         end
         s256_pkg::CORE_ROUND: begin
            msg_in   = {msg_ff[479:0], w_new};
            wk_in[7] = wk_ff[6];
            wk_in[6] = wk_ff[5];
            wk_in[5] = wk_ff[4];
            wk_in[4] = wk_ff[3] + t1;
            wk_in[3] = wk_ff[2];
            wk_in[2] = wk_ff[1];
            wk_in[1] = wk_ff[0];
            wk_in[0] = t1 + t2;
            rnd_in   = rnd_ff + 6'd1;
            if (rnd_ff == s256_pkg::LAST_ROUND) begin
               state_in = s256_pkg::CORE_ADD;
            end
         end
         s256_pkg::CORE_ADD: begin
            for (int i = 0; i < 8; i++) begin
               chain_in[i] = chain_ff[i] + wk_ff[i];
            end
            state_in = s256_pkg::CORE_IDLE;
         end
         default: begin
            state_in = s256_pkg::CORE_IDLE;
         end
      endcase
   end

   // Control and chaining registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= s256_pkg::CORE_IDLE;
         rnd_ff   <= 6'd0;
         chain_ff <= s256_pkg::INIT_H;
      end else begin
         state_ff <= state_in;
         rnd_ff   <= rnd_in;
         chain_ff <= chain_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      wk_ff  <= wk_in;
      msg_ff <= msg_in;
   end

   assign stat.busy = (state_ff != s256_pkg::CORE_IDLE);
   assign stat.done = (state_ff == s256_pkg::CORE_ADD);
   assign chain     = chain_ff;

`ifndef SYNTHESIS
   // A block always runs its last round into the final add
   a_round_to_add: assert property (@(posedge clock) disable iff (reset)
      (state_ff == s256_pkg::CORE_ROUND && rnd_ff == s256_pkg::LAST_ROUND)
      |=> (state_ff == s256_pkg::CORE_ADD))
      else $error("core: last round not followed by final add");

   // Start only arrives while the core is idle
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |-> (state_ff == s256_pkg::CORE_IDLE))
      else $error("core: start while busy");

   // Start launches round zero on the next cycle
   a_start_round0: assert property (@(posedge clock) disable iff (reset)
      (ctrl.start && state_ff == s256_pkg::CORE_IDLE)
      |=> (state_ff == s256_pkg::CORE_ROUND && rnd_ff == 6'd0))
      else $error("core: start did not launch round zero");
`endif

endmodule

`default_nettype wire

/* bench/sha256_stream_hasher_test.sv */
// Self-checking bench for sha256_stream_hasher: a directed table, then random messages.
// Depends on s256_pkg, s256_req_if, s256_rsp_if and the RTL top level.
`timescale 1ns / 1ps

module sha256_stream_hasher_test;

   localparam int CLK_HALF      = 2;
   localparam int MAX_GAP       = 18;
   localparam int LONG_HOLD     = 300;
   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 300;
   localparam int N_ROWS        = 11;
   localparam int N_BOUNDARY    = 1;
   localparam int N_RANDOM_MSGS = 3;

   localparam logic [7:0] PAD_BYTE   = 8'h80;
   localparam int         LEN_OFFSET = 56;

   // Well-known digests, word 0 in the top bits
   localparam logic [255:0] EMPTY_DIGEST =
      256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
   localparam logic [255:0] ABC_DIGEST =
      256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } digest_beat_type;

   // One directed word; a typed digest replaces the computed one on a finish
   typedef struct packed {
      logic         kind;
      logic [7:0]   data_byte;
      logic         typed;
      logic [255:0] digest;
   } stim_row_type;

   logic clock;
   logic reset = 1'b1;

   s256_req_if req_bus ();
   s256_rsp_if rsp_bus ();

   sha256_stream_hasher uut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   stim_row_type dir_rows [N_ROWS] = '{
      '{s256_pkg::KIND_FINISH, 8'h00, 1'b1, EMPTY_DIGEST},   // empty message after reset
      '{s256_pkg::KIND_DATA,   8'h61, 1'b0, 256'd0},
      '{s256_pkg::KIND_DATA,   8'h62, 1'b0, 256'd0},
      '{s256_pkg::KIND_DATA,   8'h63, 1'b0, 256'd0},
      '{s256_pkg::KIND_FINISH, 8'h00, 1'b1, ABC_DIGEST},
      '{s256_pkg::KIND_DATA,   8'h00, 1'b0, 256'd0},         // byte extremes
      '{s256_pkg::KIND_DATA,   8'hff, 1'b0, 256'd0},
      '{s256_pkg::KIND_FINISH, 8'h00, 1'b0, 256'd0},
      '{s256_pkg::KIND_DATA,   8'h80, 1'b0, 256'd0},
      '{s256_pkg::KIND_FINISH, 8'hff, 1'b0, 256'd0},         // data byte ignored on a finish
      '{s256_pkg::KIND_FINISH, 8'h5a, 1'b1, EMPTY_DIGEST}    // back-to-back finish
   };

   // A full data block, then a finish past byte 56 that needs an extra padding block
   int boundary_lens [N_BOUNDARY] = '{120};

   logic [31:0] round_const [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   logic [31:0] h_init [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   // Hash state mirrored by the bench
   logic [31:0] sha_chain [8];
   logic [7:0]  sha_block [64];
   logic [5:0]  sha_fill;
   logic [60:0] sha_len;

   digest_beat_type pending_digest_words [$];
   int              mismatches;
   int              idle_cycles;
   bit              sender_burst;
   bit              rsp_long_hold;

   function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   function void sha_restart();
      for (int i = 0; i < 8; i++) sha_chain[i] = h_init[i];
      sha_fill = '0;
      sha_len  = '0;
   endfunction

   // 64 rounds over sha_block, folded into the chain
   function void sha_compress();
      logic [31:0] w [64];
      logic [31:0] v [8];
      logic [31:0] s0, s1, t1, t2;
      for (int i = 0; i < 16; i++)
         w[i] = {sha_block[4*i], sha_block[4*i+1], sha_block[4*i+2], sha_block[4*i+3]};
      for (int i = 16; i < 64; i++) begin
         s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
         s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
         w[i] = w[i-16] + s0 + w[i-7] + s1;
      end
      for (int i = 0; i < 8; i++) v[i] = sha_chain[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_const[i] + w[i];
         t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) sha_chain[i] = sha_chain[i] + v[i];
   endfunction

   function void sha_absorb(input logic [7:0] b);
      sha_block[sha_fill] = b;
      sha_len  = sha_len + 1'b1;
      sha_fill = sha_fill + 1'b1;
      if (sha_fill == 6'd0) sha_compress();
   endfunction

   // Pad, close the message and return the digest, word 0 on top
   function logic [255:0] sha_finish();
      logic [63:0]  bit_len;
      logic [255:0] d;
      int           pos;
      bit_len = {sha_len, 3'b000};
      pos = sha_fill;
      sha_block[pos] = PAD_BYTE;
      pos++;
      // no room left for the length: close this block, start another
      if (pos > LEN_OFFSET) begin
         while (pos < 64) begin sha_block[pos] = 8'h00; pos++; end
         sha_compress();
         pos = 0;
      end
      while (pos < LEN_OFFSET) begin sha_block[pos] = 8'h00; pos++; end
      for (int i = 0; i < 8; i++) sha_block[LEN_OFFSET + i] = bit_len[63 - 8*i -: 8];
      sha_compress();
      for (int i = 0; i < 8; i++) d[255 - 32*i -: 32] = sha_chain[i];
      sha_restart();
      return d;
   endfunction

   function void push_digest(input logic [255:0] d);
      digest_beat_type beat;
      for (int i = 0; i < 8; i++) begin
         beat.digest_word = d[255 - 32*i -: 32];
         beat.word_index  = i[2:0];
         beat.last_word   = (i == 7);
         pending_digest_words = {pending_digest_words, beat};
      end
   endfunction

   task flag_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // Offer one word after a random gap (none in a burst), then account for it once taken
   task send_word(input logic kind, input logic [7:0] b, input logic typed,
                  input logic [255:0] typed_digest);
      int           gap;
      logic [255:0] d;
      gap = sender_burst ? 0 : $urandom_range(0, MAX_GAP);
      repeat (gap) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
      end
      @(negedge clock);
      req_bus.valid     <= 1'b1;
      req_bus.kind      <= kind;
      req_bus.data_byte <= b;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      if (kind == s256_pkg::KIND_DATA) begin
         sha_absorb(b);
      end else begin
         d = sha_finish();
         push_digest(typed ? typed_digest : d);
      end
   endtask

   task send_message(input int len);
      for (int i = 0; i < len; i++)
         send_word(s256_pkg::KIND_DATA, 8'($urandom_range(0, 255)), 1'b0, '0);
      send_word(s256_pkg::KIND_FINISH, 8'($urandom_range(0, 255)), 1'b0, '0);
   endtask

   task wait_digests_out();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (pending_digest_words.size() != 0) @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // Result side: random stalls, one long hold-off on request
   initial begin
      int              gap;
      int              seen;
      bit              burst;
      digest_beat_type exp_beat;
      rsp_bus.ready = 1'b0;
      seen  = 0;
      burst = 1'b0;
      wait (reset == 1'b0);
      forever begin
         if (seen % 8 == 0) burst = ($urandom_range(0, 3) == 0);
         if (rsp_long_hold) begin
            rsp_long_hold = 1'b0;
            gap = LONG_HOLD;
         end else begin
            gap = burst ? 0 : $urandom_range(0, MAX_GAP);
         end
         repeat (gap) begin
            @(negedge clock);
            rsp_bus.ready <= 1'b0;
         end
         @(negedge clock);
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         seen++;
         if (pending_digest_words.size() == 0) begin
            flag_mismatch($sformatf("unexpected digest word %h", rsp_bus.digest_word));
         end else begin
            exp_beat = pending_digest_words.pop_front();
            if (rsp_bus.digest_word !== exp_beat.digest_word)
               flag_mismatch($sformatf("digest_word %h, want %h (index %0d)",
                  rsp_bus.digest_word, exp_beat.digest_word, exp_beat.word_index));
            if (rsp_bus.word_index !== exp_beat.word_index)
               flag_mismatch($sformatf("word_index %0d, want %0d",
                  rsp_bus.word_index, exp_beat.word_index));
            if (rsp_bus.last_word !== exp_beat.last_word)
               flag_mismatch($sformatf("last_word %b, want %b (index %0d)",
                  rsp_bus.last_word, exp_beat.last_word, exp_beat.word_index));
         end
      end
   end

   // Watchdog on cycles with no word moving either way
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("sha256_stream_hasher test failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // Main stimulus
   initial begin
      int len;
      req_bus.valid     = 1'b0;
      req_bus.kind      = s256_pkg::KIND_DATA;
      req_bus.data_byte = 8'h00;
      mismatches    = 0;
      idle_cycles   = 0;
      sender_burst  = 1'b0;
      rsp_long_hold = 1'b0;
      sha_restart();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < N_ROWS; r++)
         send_word(dir_rows[r].kind, dir_rows[r].data_byte, dir_rows[r].typed,
                   dir_rows[r].digest);
      wait_digests_out();

      // padding edge case; a long receiver hold-off follows the first word of its digest
      rsp_long_hold = 1'b1;
      for (int m = 0; m < N_BOUNDARY; m++) begin
         sender_burst = ($urandom_range(0, 3) == 0);
         send_message(boundary_lens[m]);
      end

      // random short messages; the first one keeps pushing during the hold-off
      for (int m = 0; m < N_RANDOM_MSGS; m++) begin
         if (m != 0 && $urandom_range(0, 3) == 0) wait_digests_out();
         sender_burst = ($urandom_range(0, 3) == 0);
         len = $urandom_range(0, 12);
         send_message(len);
      end

      wait_digests_out();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("sha256_stream_hasher test passed");
      end else begin
         $display("sha256_stream_hasher test failed");
      end
      $finish;
   end

endmodule

/* sha256_stream_hasher.f */
rtl/s256_pkg.sv
rtl/s256_req_if.sv
rtl/s256_rsp_if.sv
rtl/s256_core.sv
rtl/sha256_stream_hasher.sv
bench/sha256_stream_hasher_test.sv
